### rtl/mer_pkg.sv
// Shared widths, codes and controller/datapath interface types of the ellipse rasterizer.
package mer_pkg;

  // Field widths
  localparam int RADIUS_W = 11;
  localparam int COORD_W  = 12;
  localparam int PIX_W    = 14;
  // Step coordinates carry enough bits for the pixel wrap and for the sign of y
  localparam int STEP_W   = 14;
  // Squared radius
  localparam int SQ_W     = 2 * RADIUS_W;
  // Slopes and decision: four times the real decision value
  localparam int WIDE_W   = 48;
  // Shared multiplier operand width
  localparam int MUL_W    = 2 * STEP_W;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = ((2 * PIX_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = COORD_W;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 2'd3;

  // Pixel order within one step
  localparam logic [1:0] PIX_XP_YP = 2'd0;
  localparam logic [1:0] PIX_XN_YP = 2'd1;
  localparam logic [1:0] PIX_XP_YN = 2'd2;
  localparam logic [1:0] PIX_XN_YN = 2'd3;

  // Drawing phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2
  } phase_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQD,
    ST_LDM,
    ST_LOAD,
    ST_SETTLE,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_D4,
    ST_D5,
    ST_D6,
    ST_PIX,
    ST_OUT0,
    ST_OUT1,
    ST_OUT2,
    ST_UPD1,
    ST_UPD2,
    ST_OUT3
  } state_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQX,   // prod = rx * rx
    OP_SQY,   // rx2 = prod, prod = ry * ry
    OP_SQD,   // ry2 = prod
    OP_LDM,   // prod = rx2 * ry
    OP_LOAD,  // load generator at (0, ry)
    OP_TX,    // prod = (2x+1)^2
    OP_RYT,   // prod = ry2 * prod
    OP_TY,    // dec = prod, prod = (y-1)^2
    OP_RXT,   // prod = rx2 * prod
    OP_RR,    // dec += 4*prod, prod = rx2 * ry2
    OP_DEC2,  // dec -= 4*prod
    OP_PIX,   // latch the four pixel coordinates
    OP_UPD1,  // step coordinates and slopes
    OP_UPD2   // decision update from new slopes
  } dp_op_t;

  typedef struct packed {
    logic       in_ready;
    dp_op_t     op;
    logic       region2;
    logic       load_out;
    logic [1:0] out_sel;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic restart;
    logic slope_ge;
    logic y_neg;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/mer_dp.sv
// Datapath of the ellipse rasterizer: config, shared multiplier, step state, output register.
module mer_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mer_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [mer_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 s_tvalid,
  input  logic [mer_pkg::IN_DATA_W-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [mer_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic                                 m_tlast,
  input  mer_pkg::dp_cmd_t                     cmd,
  output mer_pkg::dp_status_t                  status
);

  localparam int RW = mer_pkg::RADIUS_W;
  localparam int CW = mer_pkg::COORD_W;
  localparam int PW = mer_pkg::PIX_W;
  localparam int SW = mer_pkg::STEP_W;
  localparam int QW = mer_pkg::SQ_W;
  localparam int WW = mer_pkg::WIDE_W;
  localparam int MW = mer_pkg::MUL_W;

  // Configuration registers
  logic [RW-1:0] radius_x;
  logic [RW-1:0] radius_y;
  logic [CW-1:0] center_x;
  logic [CW-1:0] center_y;

  // Algorithm state
  logic          restart;
  logic [QW-1:0] rx2;
  logic [QW-1:0] ry2;
  logic [2*MW-1:0] prod;
  logic [SW-1:0] step_x;
  logic [SW-1:0] step_y;
  logic [WW-1:0] slope_dx;
  logic [WW-1:0] slope_dy;
  logic [WW-1:0] decision;
  logic [PW-1:0] xp, xn, yp, yn;

  // Shared multiplier operands
  logic          mul_en;
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;

  // Derived values
  logic [WW-1:0] rx2_w, ry2_w, prod_w, prod_x4, ry2_x2, rx2_x2;
  logic [SW-1:0] ty, ty_abs;
  logic [MW-1:0] tx_w, ty_w, rx2_m, ry2_m, prod_m;
  logic [PW-1:0] cx_w, cy_w, sx_w, sy_w;
  logic          dec_neg, dec_pos;
  logic [PW-1:0] sel_x, sel_y;

  assign rx2_w   = {{(WW-QW){1'b0}}, rx2};
  assign ry2_w   = {{(WW-QW){1'b0}}, ry2};
  assign rx2_x2  = {rx2_w[WW-2:0], 1'b0};
  assign ry2_x2  = {ry2_w[WW-2:0], 1'b0};
  assign prod_w  = prod[WW-1:0];
  assign prod_x4 = {prod_w[WW-3:0], 2'b00};
  assign ty      = step_y - {{(SW-1){1'b0}}, 1'b1};
  assign ty_abs  = ty[SW-1] ? (~ty + {{(SW-1){1'b0}}, 1'b1}) : ty;
  assign tx_w    = {{(MW-SW-1){1'b0}}, step_x, 1'b1};
  assign ty_w    = {{(MW-SW){1'b0}}, ty_abs};
  assign rx2_m   = {{(MW-QW){1'b0}}, rx2};
  assign ry2_m   = {{(MW-QW){1'b0}}, ry2};
  assign prod_m  = prod[MW-1:0];
  assign cx_w    = {{(PW-CW){1'b0}}, center_x};
  assign cy_w    = {{(PW-CW){1'b0}}, center_y};
  assign sx_w    = step_x[PW-1:0];
  assign sy_w    = step_y[PW-1:0];
  assign dec_neg = decision[WW-1];
  assign dec_pos = !decision[WW-1] && (decision != '0);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x <= '0;
      radius_y <= '0;
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        mer_pkg::CFG_RADIUS_X: radius_x <= cfg_wdata[RW-1:0];
        mer_pkg::CFG_RADIUS_Y: radius_y <= cfg_wdata[RW-1:0];
        mer_pkg::CFG_CENTER_X: center_x <= cfg_wdata;
        mer_pkg::CFG_CENTER_Y: center_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.in_ready && s_tvalid) begin
      restart <= s_tdata[0];
    end
  end

  // Select multiplier operands
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      mer_pkg::OP_SQX: begin
        mul_a = {{(MW-RW){1'b0}}, radius_x};
        mul_b = {{(MW-RW){1'b0}}, radius_x};
      end
      mer_pkg::OP_SQY: begin
        mul_a = {{(MW-RW){1'b0}}, radius_y};
        mul_b = {{(MW-RW){1'b0}}, radius_y};
      end
      mer_pkg::OP_LDM: begin
        mul_a = rx2_m;
        mul_b = {{(MW-RW){1'b0}}, radius_y};
      end
      mer_pkg::OP_TX: begin
        mul_a = tx_w;
        mul_b = tx_w;
      end
      mer_pkg::OP_RYT: begin
        mul_a = ry2_m;
        mul_b = prod_m;
      end
      mer_pkg::OP_TY: begin
        mul_a = ty_w;
        mul_b = ty_w;
      end
      mer_pkg::OP_RXT: begin
        mul_a = rx2_m;
        mul_b = prod_m;
      end
      mer_pkg::OP_RR: begin
        mul_a = rx2_m;
        mul_b = ry2_m;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Advance squares, slopes, decision and step coordinates
  always_ff @(posedge clk) begin
    case (cmd.op)
      mer_pkg::OP_SQY: rx2 <= prod[QW-1:0];
      mer_pkg::OP_SQD: ry2 <= prod[QW-1:0];
      mer_pkg::OP_LOAD: begin
        step_x   <= '0;
        step_y   <= {{(SW-RW){1'b0}}, radius_y};
        slope_dx <= '0;
        slope_dy <= {prod_w[WW-2:0], 1'b0};
        decision <= {ry2_w[WW-3:0], 2'b00} - prod_x4 + rx2_w;
      end
      mer_pkg::OP_TY:   decision <= prod_w;
      mer_pkg::OP_RR:   decision <= decision + prod_x4;
      mer_pkg::OP_DEC2: decision <= decision - prod_x4;
      mer_pkg::OP_PIX: begin
        xp <= cx_w + sx_w;
        xn <= cx_w - sx_w;
        yp <= cy_w + sy_w;
        yn <= cy_w - sy_w;
      end
      mer_pkg::OP_UPD1: begin
        if (!cmd.region2) begin
          step_x   <= step_x + {{(SW-1){1'b0}}, 1'b1};
          slope_dx <= slope_dx + ry2_x2;
          if (!dec_neg) begin
            step_y   <= step_y - {{(SW-1){1'b0}}, 1'b1};
            slope_dy <= slope_dy - rx2_x2;
          end
        end else begin
          step_y   <= step_y - {{(SW-1){1'b0}}, 1'b1};
          slope_dy <= slope_dy - rx2_x2;
          if (!dec_pos) begin
            step_x   <= step_x + {{(SW-1){1'b0}}, 1'b1};
            slope_dx <= slope_dx + ry2_x2;
          end
        end
      end
      mer_pkg::OP_UPD2: begin
        // decision is still the pre-step value, so the branch matches UPD1
        if (!cmd.region2) begin
          if (dec_neg) begin
            decision <= decision + {slope_dx[WW-3:0] + ry2_w[WW-3:0], 2'b00};
          end else begin
            decision <= decision +
                        {slope_dx[WW-3:0] - slope_dy[WW-3:0] + ry2_w[WW-3:0], 2'b00};
          end
        end else begin
          if (dec_pos) begin
            decision <= decision + {rx2_w[WW-3:0] - slope_dy[WW-3:0], 2'b00};
          end else begin
            decision <= decision +
                        {slope_dx[WW-3:0] - slope_dy[WW-3:0] + rx2_w[WW-3:0], 2'b00};
          end
        end
      end
      default: ;
    endcase
  end

  // Pick the pixel for the output beat
  always_comb begin
    case (cmd.out_sel)
      mer_pkg::PIX_XP_YP: begin sel_x = xp; sel_y = yp; end
      mer_pkg::PIX_XN_YP: begin sel_x = xn; sel_y = yp; end
      mer_pkg::PIX_XP_YN: begin sel_x = xp; sel_y = yn; end
      mer_pkg::PIX_XN_YN: begin sel_x = xn; sel_y = yn; end
      default:            begin sel_x = xn; sel_y = yn; end
    endcase
  end

  // Output register: load a beat or drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {{(mer_pkg::OUT_DATA_W-2*PW){1'b0}}, sel_y, sel_x};
      m_tlast <= cmd.out_last;
    end
  end

  // Status toward the controller
  assign status.restart  = restart;
  assign status.slope_ge = !($signed(slope_dx) < $signed(slope_dy));
  assign status.y_neg    = step_y[SW-1];
  assign status.out_free = !m_tvalid || m_tready;

endmodule

### rtl/mer_ctrl.sv
// Controller of the ellipse rasterizer: sequences the shared multiplier, steps and pixel beats.
module mer_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  mer_pkg::dp_status_t status,
  output mer_pkg::dp_cmd_t    cmd
);

  mer_pkg::state_t state, state_next;
  mer_pkg::phase_t phase, phase_next;

  // Hold state and drawing phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mer_pkg::ST_IDLE;
      phase <= mer_pkg::PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next   = state;
    phase_next   = phase;
    cmd.in_ready = 1'b0;
    cmd.op       = mer_pkg::OP_NONE;
    cmd.region2  = (phase == mer_pkg::PH_R2);
    cmd.load_out = 1'b0;
    cmd.out_sel  = mer_pkg::PIX_XP_YP;
    cmd.out_last = 1'b0;
    case (state)
      mer_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (s_tvalid) state_next = mer_pkg::ST_SQX;
      end
      // Square both radii from the live configuration
      mer_pkg::ST_SQX: begin
        cmd.op     = mer_pkg::OP_SQX;
        state_next = mer_pkg::ST_SQY;
      end
      mer_pkg::ST_SQY: begin
        cmd.op     = mer_pkg::OP_SQY;
        state_next = mer_pkg::ST_SQD;
      end
      mer_pkg::ST_SQD: begin
        cmd.op = mer_pkg::OP_SQD;
        if (status.restart) begin
          state_next = mer_pkg::ST_LDM;
        end else if (phase == mer_pkg::PH_IDLE) begin
          state_next = mer_pkg::ST_IDLE;
        end else begin
          state_next = mer_pkg::ST_PIX;
        end
      end
      // Reload the generator at (0, ry)
      mer_pkg::ST_LDM: begin
        cmd.op     = mer_pkg::OP_LDM;
        state_next = mer_pkg::ST_LOAD;
      end
      mer_pkg::ST_LOAD: begin
        cmd.op     = mer_pkg::OP_LOAD;
        phase_next = mer_pkg::PH_R1;
        state_next = mer_pkg::ST_SETTLE;
      end
      // Enter region 2 or finish when the tests demand it
      mer_pkg::ST_SETTLE: begin
        if (phase == mer_pkg::PH_R1 && status.slope_ge) begin
          state_next = mer_pkg::ST_D1;
        end else begin
          if (phase == mer_pkg::PH_R2 && status.y_neg) phase_next = mer_pkg::PH_IDLE;
          state_next = status.restart ? mer_pkg::ST_IDLE : mer_pkg::ST_OUT3;
        end
      end
      // Region-2 decision, one product per cycle
      mer_pkg::ST_D1: begin
        cmd.op     = mer_pkg::OP_TX;
        state_next = mer_pkg::ST_D2;
      end
      mer_pkg::ST_D2: begin
        cmd.op     = mer_pkg::OP_RYT;
        state_next = mer_pkg::ST_D3;
      end
      mer_pkg::ST_D3: begin
        cmd.op     = mer_pkg::OP_TY;
        state_next = mer_pkg::ST_D4;
      end
      mer_pkg::ST_D4: begin
        cmd.op     = mer_pkg::OP_RXT;
        state_next = mer_pkg::ST_D5;
      end
      mer_pkg::ST_D5: begin
        cmd.op     = mer_pkg::OP_RR;
        state_next = mer_pkg::ST_D6;
      end
      mer_pkg::ST_D6: begin
        cmd.op     = mer_pkg::OP_DEC2;
        phase_next = mer_pkg::PH_R2;
        state_next = mer_pkg::ST_SETTLE;
      end
      // Latch the four pixels of the current point
      mer_pkg::ST_PIX: begin
        cmd.op     = mer_pkg::OP_PIX;
        state_next = mer_pkg::ST_OUT0;
      end
      mer_pkg::ST_OUT0: begin
        cmd.out_sel  = mer_pkg::PIX_XP_YP;
        cmd.load_out = status.out_free;
        if (status.out_free) state_next = mer_pkg::ST_OUT1;
      end
      mer_pkg::ST_OUT1: begin
        cmd.out_sel  = mer_pkg::PIX_XN_YP;
        cmd.load_out = status.out_free;
        if (status.out_free) state_next = mer_pkg::ST_OUT2;
      end
      mer_pkg::ST_OUT2: begin
        cmd.out_sel  = mer_pkg::PIX_XP_YN;
        cmd.load_out = status.out_free;
        if (status.out_free) state_next = mer_pkg::ST_UPD1;
      end
      // Advance one midpoint step
      mer_pkg::ST_UPD1: begin
        cmd.op     = mer_pkg::OP_UPD1;
        state_next = mer_pkg::ST_UPD2;
      end
      mer_pkg::ST_UPD2: begin
        cmd.op     = mer_pkg::OP_UPD2;
        state_next = mer_pkg::ST_SETTLE;
      end
      // Fourth pixel carries last once the ellipse is finished
      mer_pkg::ST_OUT3: begin
        cmd.out_sel  = mer_pkg::PIX_XN_YN;
        cmd.out_last = (phase == mer_pkg::PH_IDLE);
        cmd.load_out = status.out_free;
        if (status.out_free) state_next = mer_pkg::ST_IDLE;
      end
      default: begin
        state_next = mer_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/midpoint_ellipse_raster.sv
// Top level of the midpoint ellipse rasterizer: controller and datapath.
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tdata[0] restart, [7:1] zero
// m_*       out  tvalid/tready      tdata[13:0] pixel_x, [27:14] pixel_y, tlast last_pixel
// cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// One shared 28x28 multiplier sets the pace: each tick squares both radii first.
// A drawing tick then latches its pixels, sends three, steps and settles, runs the
// region-2 decision if region 2 begins, and sends the fourth; output stalls hold it.
// A restart tick reloads the generator and may enter region 2; an idle tick only squares.
// Reset (rst, synchronous) clears the configuration and leaves the generator finished.
// Input is taken only between ticks; a stalled output beat holds until taken.
module midpoint_ellipse_raster (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mer_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mer_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mer_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] restart, [7:1] zero
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mer_pkg::OUT_DATA_W-1:0]   m_tdata,   // [13:0] pixel_x, [27:14] pixel_y
  output logic                             m_tlast
);

  mer_pkg::dp_cmd_t    cmd;
  mer_pkg::dp_status_t status;

  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  mer_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

  assign s_tready = cmd.in_ready;

endmodule

### rtl/mer_chk.sv
// Port-level checker for the ellipse rasterizer, bound to the top level.
module mer_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [mer_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mer_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output beat changed while stalled");

  // One tick at a time: the block is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // Input ready falls only right after an accepted input beat
  a_ready_falls_on_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid && s_tready))
    else $error("input ready dropped without an accepted beat");

  // A restart gives no pixel of its own
  a_restart_quiet: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[0] && (!m_tvalid || m_tready)) |=> !m_tvalid)
    else $error("pixel emitted right after a restart");

endmodule

bind midpoint_ellipse_raster mer_chk u_mer_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the midpoint ellipse rasterizer: directed and random ticks.
`timescale 1ns / 100ps

module tb_top;

  localparam int RANDOM_ITEMS  = 370;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SHOW_MAX      = 10;

  // One expected output beat
  typedef struct packed {
    logic [mer_pkg::PIX_W-1:0] px;
    logic [mer_pkg::PIX_W-1:0] py;
    logic                      last;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [mer_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [mer_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [mer_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [mer_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;

  // Shadow of the generator and its registers, 64-bit wrapping like the spec
  logic [63:0]      rad_x, rad_y, cen_x, cen_y;
  logic [63:0]      gen_x, gen_y, gen_dx, gen_dy, gen_dec;
  mer_pkg::phase_t  gen_phase;

  pixel_t pixels_due[$];
  pixel_t want;
  bit     feed_on = 1'b0;
  bit     calm = 1'b0;
  int     mismatches = 0;
  int     beats_seen = 0;
  int     ticks_sent = 0;
  int     drawing_items = 0;
  int     ellipses_done = 0;
  int     cycles = 0;

  midpoint_ellipse_raster u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, pixels_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stall the output side about 23% of cycles, except in the calm stretch
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 23);
  end

  // ---------------------------------------------------------------- predictor

  task automatic enter_region2();
    logic [63:0] rx2, ry2, tx, ty;
    rx2 = rad_x * rad_x;
    ry2 = rad_y * rad_y;
    if (gen_phase == mer_pkg::PH_R1 && !($signed(gen_dx) < $signed(gen_dy))) begin
      tx = 64'd2 * gen_x + 64'd1;
      ty = gen_y - 64'd1;
      gen_dec = ry2 * tx * tx + 64'd4 * rx2 * ty * ty - 64'd4 * rx2 * ry2;
      gen_phase = mer_pkg::PH_R2;
    end
    if (gen_phase == mer_pkg::PH_R2 && gen_y[63])
      gen_phase = mer_pkg::PH_IDLE;
  endtask

  task automatic push_pixel(input logic [63:0] px, input logic [63:0] py, input bit last);
    pixel_t p;
    p.px = px[mer_pkg::PIX_W-1:0];
    p.py = py[mer_pkg::PIX_W-1:0];
    p.last = last;
    pixels_due.push_back(p);
  endtask

  // Advance the shadow generator by one accepted tick and queue its pixels
  task automatic ellipse_step(input bit restart);
    logic [63:0] rx2, ry2, xp, xn, yp, yn;
    rx2 = rad_x * rad_x;
    ry2 = rad_y * rad_y;
    ticks_sent++;
    if (restart) begin
      drawing_items++;
      gen_x = 64'd0;
      gen_y = rad_y;
      gen_dx = 64'd0;
      gen_dy = 64'd2 * rx2 * rad_y;
      gen_dec = 64'd4 * ry2 - 64'd4 * rx2 * rad_y + rx2;
      gen_phase = mer_pkg::PH_R1;
      enter_region2();
    end else if (gen_phase != mer_pkg::PH_IDLE) begin
      drawing_items++;
      xp = cen_x + gen_x;
      xn = cen_x - gen_x;
      yp = cen_y + gen_y;
      yn = cen_y - gen_y;
      push_pixel(xp, yp, 1'b0);
      push_pixel(xn, yp, 1'b0);
      push_pixel(xp, yn, 1'b0);
      if (gen_phase == mer_pkg::PH_R1) begin
        gen_x = gen_x + 64'd1;
        gen_dx = gen_dx + 64'd2 * ry2;
        if (gen_dec[63]) begin
          gen_dec = gen_dec + 64'd4 * (gen_dx + ry2);
        end else begin
          gen_y = gen_y - 64'd1;
          gen_dy = gen_dy - 64'd2 * rx2;
          gen_dec = gen_dec + 64'd4 * (gen_dx - gen_dy + ry2);
        end
      end else begin
        gen_y = gen_y - 64'd1;
        gen_dy = gen_dy - 64'd2 * rx2;
        if (!gen_dec[63] && gen_dec != 64'd0) begin
          gen_dec = gen_dec + 64'd4 * (rx2 - gen_dy);
        end else begin
          gen_x = gen_x + 64'd1;
          gen_dx = gen_dx + 64'd2 * ry2;
          gen_dec = gen_dec + 64'd4 * (gen_dx - gen_dy + rx2);
        end
      end
      enter_region2();
      if (gen_phase == mer_pkg::PH_IDLE)
        ellipses_done++;
      push_pixel(xn, yn, gen_phase == mer_pkg::PH_IDLE);
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Write one register; cfg_we stays high until cfg_done
  task automatic write_reg(input logic [mer_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [mer_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    case (addr)
      mer_pkg::CFG_RADIUS_X: rad_x = {53'd0, val[mer_pkg::RADIUS_W-1:0]};
      mer_pkg::CFG_RADIUS_Y: rad_y = {53'd0, val[mer_pkg::RADIUS_W-1:0]};
      mer_pkg::CFG_CENTER_X: cen_x = {52'd0, val[mer_pkg::COORD_W-1:0]};
      default:               cen_y = {52'd0, val[mer_pkg::COORD_W-1:0]};
    endcase
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(input logic [11:0] rx, input logic [11:0] ry,
                             input logic [11:0] cx, input logic [11:0] cy);
    write_reg(mer_pkg::CFG_RADIUS_X, rx);
    write_reg(mer_pkg::CFG_RADIUS_Y, ry);
    write_reg(mer_pkg::CFG_CENTER_X, cx);
    write_reg(mer_pkg::CFG_CENTER_Y, cy);
    cfg_done();
  endtask

  // Send one tick beat; tvalid is left high for a back-to-back follow-up
  task automatic send_tick(input bit restart);
    if (!calm && $urandom_range(99) < 23) begin
      if (feed_on) begin
        s_tvalid <= 1'b0;
        feed_on = 1'b0;
      end
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    feed_on = 1'b1;
    s_tdata <= {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    ellipse_step(restart);
  endtask

  // Drop tvalid, wait for every due pixel, then let the last tick finish
  task automatic drain();
    if (feed_on) begin
      s_tvalid <= 1'b0;
      feed_on = 1'b0;
    end
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic ticks_to_end(input int cap);
    int n;
    n = 0;
    while (gen_phase != mer_pkg::PH_IDLE && n < cap) begin
      send_tick(1'b0);
      n++;
    end
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("beat %0d: %s expected %0d, got %0d", beats_seen, name, exp_v, got_v);
    end
  endtask

  // Compare each accepted output beat with the oldest due pixel
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("beat %0d: unexpected pixel x=%0d y=%0d last=%0b", beats_seen,
                   $signed(m_tdata[mer_pkg::PIX_W-1:0]),
                   $signed(m_tdata[2*mer_pkg::PIX_W-1:mer_pkg::PIX_W]), m_tlast);
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_x", int'($signed(want.px)),
                    int'($signed(m_tdata[mer_pkg::PIX_W-1:0])));
        check_field("pixel_y", int'($signed(want.py)),
                    int'($signed(m_tdata[2*mer_pkg::PIX_W-1:mer_pkg::PIX_W])));
        check_field("last_pixel", int'(want.last), int'(m_tlast));
      end
      beats_seen++;
    end
  end

  // ---------------------------------------------------------------- tests

  // Ticks after reset find the generator finished
  task automatic test_idle_after_reset();
    repeat (3) send_tick(1'b0);
    drain();
  endtask

  // Zero radii and one-axis ellipses enter region 2 at restart
  task automatic test_degenerate();
    program_all(12'd0, 12'd0, 12'd0, 12'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();
    program_all(12'd2047, 12'd0, 12'd4095, 12'd4095);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
    // Long vertical line: abandon it with a restart after a few steps
    program_all(12'd0, 12'd2047, 12'd0, 12'd4095);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    drain();
  endtask

  // A small ellipse from restart to its last pixel, then an extra idle tick
  task automatic test_full_small();
    program_all(12'd3, 12'd2, 12'd100, 12'd50);
    send_tick(1'b1);
    ticks_to_end(50);
    send_tick(1'b0);
    drain();
  endtask

  // Largest radii, with live register changes between steps
  task automatic test_max_radii();
    program_all(12'd2047, 12'd2047, 12'd2048, 12'd2048);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();
    write_reg(mer_pkg::CFG_CENTER_X, 12'd0);
    write_reg(mer_pkg::CFG_RADIUS_X, 12'd1000);
    cfg_done();
    repeat (2) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
  endtask

  task automatic test_random_ellipses();
    int          first;
    int          mode;
    bit          big;
    logic [11:0] rx, ry, cx, cy, val;
    first = ticks_sent;
    while (ticks_sent < first + RANDOM_ITEMS) begin
      // Run without idling on either side for part of the run
      calm = (ticks_sent >= first + 150) && (ticks_sent < first + 240);
      drain();
      big = ($urandom_range(9) == 0);
      rx = big ? 12'($urandom_range(2047)) : 12'($urandom_range(12));
      ry = big ? 12'($urandom_range(2047)) : 12'($urandom_range(12));
      case ($urandom_range(5))
        0:       cx = 12'd0;
        1:       cx = 12'd4095;
        default: cx = 12'($urandom_range(4095));
      endcase
      case ($urandom_range(5))
        0:       cy = 12'd0;
        1:       cy = 12'd4095;
        default: cy = 12'($urandom_range(4095));
      endcase
      program_all(rx, ry, cx, cy);
      mode = $urandom_range(9);
      if (mode == 9) begin
        // Noise: random restart bits
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)));
      end else begin
        send_tick(1'b1);
        if (big) begin
          // Large radii: only a few steps
          repeat ($urandom_range(1, 6)) send_tick(1'b0);
        end else if (mode == 8) begin
          // Change one register between steps of a drawing
          repeat ($urandom_range(0, 4)) send_tick(1'b0);
          drain();
          val = 12'($urandom_range(4095));
          case ($urandom_range(3))
            0:       write_reg(mer_pkg::CFG_RADIUS_X, 12'($urandom_range(1, 12)));
            1:       write_reg(mer_pkg::CFG_RADIUS_Y, 12'($urandom_range(1, 12)));
            2:       write_reg(mer_pkg::CFG_CENTER_X, val);
            default: write_reg(mer_pkg::CFG_CENTER_Y, val);
          endcase
          cfg_done();
          ticks_to_end(60);
        end else if (mode >= 6) begin
          // Abandon a partial ellipse and draw it again
          repeat ($urandom_range(0, 5)) send_tick(1'b0);
          send_tick(1'b1);
          ticks_to_end(200);
        end else begin
          ticks_to_end(200);
        end
        repeat ($urandom_range(0, 2)) send_tick(1'b0);
      end
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    rad_x = '0; rad_y = '0; cen_x = '0; cen_y = '0;
    gen_x = '0; gen_y = '0; gen_dx = '0; gen_dy = '0; gen_dec = '0;
    gen_phase = mer_pkg::PH_IDLE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_after_reset();
    test_degenerate();
    test_full_small();
    test_max_radii();
    test_random_ellipses();

    $display("sent %0d ticks (%0d restart or drawing), %0d complete ellipses",
             ticks_sent, drawing_items, ellipses_done);
    $display("checked %0d pixel beats, %0d mismatches, %0d still due",
             beats_seen, mismatches, pixels_due.size());
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
